// ===== rtl/bbdd_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilevel box downscaler package
// Beat types, register indexes, hash constants and span arithmetic helpers.
// ----------------------------------------------------------------------------
package bbdd_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
    logic [9:0]  target_row;
    logic [5:0]  target_byte_column;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       span_error;
  } res_t;

  typedef struct packed {
    logic [10:0] first;
    logic [10:0] last;
  } span_t;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_INV_SCALE  = 3'd4;

  localparam int unsigned CFG_W = 19;

  localparam logic [31:0] HASH_X   = 32'd374761393;
  localparam logic [31:0] HASH_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MIX = 32'd1274126177;

  // Centred crop offset in 16.16: half of what the source exceeds the scaled target.
  function automatic logic [25:0] crop_fn(input logic [10:0] size, input logic [29:0] prod);
    logic [29:0] s;
    logic [29:0] diff;
    s    = {3'b0, size, 16'b0};
    diff = s - prod;
    crop_fn = (s > prod) ? diff[26:1] : 26'd0;
  endfunction

  // Clamp a raw span to the image and keep it at least one pixel wide.
  function automatic span_t span_fn(input logic [14:0] a_raw, input logic [14:0] b_raw,
                                    input logic [10:0] size);
    logic [14:0] sz;
    logic [14:0] a;
    logic [14:0] b;
    span_t       r;
    sz = {4'b0, size};
    a  = (a_raw >= sz) ? (sz - 15'd1) : a_raw;
    b  = (b_raw > sz) ? sz : b_raw;
    if (b <= a) begin
      b = a + 15'd1;
    end
    if (b > sz) begin
      b = sz;
    end
    r.first = a[10:0];
    r.last  = b[10:0];
    span_fn = r;
  endfunction

endpackage

// ===== rtl/bilevel_box_downscale_dither.sv =====
// ----------------------------------------------------------------------------
// Bilevel box downscale with hashed dither
// Holds a 1-bit source image in a byte store and produces downscaled bytes.
// ----------------------------------------------------------------------------
// A load beat leaves busy_o low. A compute beat runs the set-up states
// (crop, band span, check), then per visible pixel the span states, a read
// and an accumulate for each covered source pixel, each one read from the
// single store port, a serial division and a compare. Pixels past the target
// width are skipped in S_PX. The result strobe rises in the cycle busy_o falls;
// the receiver cannot stall it. Reset clears the sequencer and the
// configuration registers to their defaults; the store content is undefined.
module bilevel_box_downscale_dither
  import bbdd_pkg::*;
#(
  parameter int unsigned STORE_BYTES       = 65536,
  parameter int unsigned MAX_ROWS_PER_BAND = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cmd_t             cmd_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // The user must size the store to a power of two, so address wrap is a plain truncation; the block does not check it.
  localparam int unsigned AW    = $clog2(STORE_BYTES);
  localparam int unsigned EXT_W = (AW > 19) ? AW : 19;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CROPY = 5'd1;
  localparam logic [4:0] S_CROPX = 5'd2;
  localparam logic [4:0] S_YS    = 5'd3;
  localparam logic [4:0] S_YE    = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_PX    = 5'd6;
  localparam logic [4:0] S_XS    = 5'd7;
  localparam logic [4:0] S_XE    = 5'd8;
  localparam logic [4:0] S_RD    = 5'd9;
  localparam logic [4:0] S_ACC   = 5'd10;
  localparam logic [4:0] S_DIV   = 5'd11;
  localparam logic [4:0] S_CMP   = 5'd12;

  // Configuration registers.
  logic [9:0]  src_w_q, dst_w_q;
  logic [10:0] src_h_q, dst_h_q;
  logic [18:0] inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 10'd480;
      src_h_q <= 11'd800;
      dst_w_q <= 10'd230;
      dst_h_q <= 11'd360;
      inv_q   <= 19'd136770;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[9:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[10:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i[9:0];
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i[10:0];
        CFG_INV_SCALE:  inv_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [4:0]  state_q, state_d;
  logic        accept;
  logic [9:0]  y_q;
  logic [5:0]  col_q;
  logic [3:0]  i_q;
  logic [8:0]  x;
  logic [10:0] mul_a;
  logic [29:0] p_q;
  logic [25:0] cy_q, cx_q;
  logic [14:0] a_q;
  logic [14:0] pos_sum;
  logic [10:0] ys_q, ye_q, r_q;
  logic [9:0]  xs_q, xe_q, sx_q;
  logic [2:0]  sxb_q;
  logic [31:0] h_q;
  logic [7:0]  w_q, cnt_q;
  logic [7:0]  rem_q;
  logic [15:0] quo_q;
  logic [3:0]  k_q;
  logic [7:0]  byte_q;
  logic        done_q;
  res_t        res_q;
  logic [7:0]  rd_q;
  logic [7:0]  stride;
  logic [18:0] raddr_full;
  logic [EXT_W-1:0] raddr_ext, waddr_ext;
  span_t       sp;
  logic [10:0] rows;
  logic        bit_w;
  logic [7:0]  w_next;
  logic [8:0]  shifted;
  logic [7:0]  t;
  logic [7:0]  thr;
  logic [31:0] h_mix;

  logic [7:0] source_store_q [STORE_BYTES];

  assign accept  = start_i && (state_q == S_IDLE);
  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign res_o   = res_q;
  assign x       = {col_q, i_q[2:0]};
  assign stride  = 8'(({1'b0, src_w_q} + 11'd7) >> 3);

  // One shared 11 x 19 multiplier serves the crop and span arithmetic.
  always_comb begin
    case (state_q)
      S_IDLE:  mul_a = dst_h_q;
      S_CROPY: mul_a = {1'b0, dst_w_q};
      S_CROPX: mul_a = {1'b0, y_q};
      S_YS:    mul_a = {1'b0, y_q} + 11'd1;
      S_PX:    mul_a = {2'b0, x};
      S_XS:    mul_a = {2'b0, x} + 11'd1;
      default: mul_a = 11'd0;
    endcase
  end

  // The band position is crop plus the scaled index, whole pixels only.
  always_comb begin
    logic [30:0] s;
    if (state_q == S_YS || state_q == S_YE) begin
      s = {5'b0, cy_q} + {1'b0, p_q};
    end else begin
      s = {5'b0, cx_q} + {1'b0, p_q};
    end
    pos_sum = s[30:16];
  end

  always_comb begin
    if (state_q == S_YE) begin
      sp = span_fn(a_q, pos_sum, src_h_q);
    end else begin
      sp = span_fn(a_q, pos_sum, {1'b0, src_w_q});
    end
  end

  assign rows       = ye_q - ys_q;
  assign raddr_full = (19'(r_q) * 19'(stride)) + 19'(sx_q[9:3]);
  assign raddr_ext  = EXT_W'(raddr_full);
  assign waddr_ext  = EXT_W'(cmd_i.load_address);
  assign bit_w      = rd_q[3'd7 - sxb_q];
  assign w_next     = w_q + 8'(bit_w);
  assign shifted    = {rem_q, quo_q[15]};
  assign h_mix      = (h_q ^ (h_q >> 13)) * HASH_MIX;

  // Threshold is 128 plus half of (top hash byte - 128), rounded toward zero.
  assign t   = h_q[31:24];
  assign thr = t[7] ? (8'd128 + ((t - 8'd128) >> 1)) : (8'd128 - ((8'd128 - t) >> 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept && cmd_i.command == CMD_COMPUTE) state_d = S_CROPY;
      S_CROPY: state_d = S_CROPX;
      S_CROPX: state_d = S_YS;
      S_YS:    state_d = S_YE;
      S_YE:    state_d = S_CHK;
      S_CHK: begin
        if (src_w_q == 10'd0 || src_h_q == 11'd0 || rows > 11'(MAX_ROWS_PER_BAND)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_PX;
        end
      end
      S_PX: begin
        if (i_q[3]) begin
          state_d = S_IDLE;
        end else if ({1'b0, x} < dst_w_q) begin
          state_d = S_XS;
        end
      end
      S_XS:  state_d = S_XE;
      S_XE:  state_d = S_RD;
      S_RD:  state_d = S_ACC;
      S_ACC: begin
        if (sx_q + 10'd1 < xe_q || r_q + 11'd1 < ye_q) begin
          state_d = S_RD;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV:   if (k_q == 4'd15) state_d = S_CMP;
      S_CMP:   state_d = S_PX;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      i_q     <= 4'd0;
      k_q     <= 4'd0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      case (state_q)
        S_CHK: begin
          i_q <= 4'd0;
          if (state_d == S_IDLE) done_q <= 1'b1;
        end
        S_PX: begin
          if (i_q[3]) begin
            done_q <= 1'b1;
          end else if (state_d == S_PX) begin
            i_q <= i_q + 4'd1;
          end
        end
        S_ACC:   k_q <= 4'd0;
        S_DIV:   k_q <= k_q + 4'd1;
        S_CMP:   i_q <= i_q + 4'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers: no reset needed, the sequencer sets them before use.
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * inv_q;
    case (state_q)
      S_IDLE: begin
        y_q    <= cmd_i.target_row;
        col_q  <= cmd_i.target_byte_column;
        byte_q <= 8'hFF;
      end
      S_CROPY: cy_q <= crop_fn(src_h_q, p_q);
      S_CROPX: cx_q <= crop_fn({1'b0, src_w_q}, p_q);
      S_YS:    a_q  <= pos_sum;
      S_YE: begin
        ys_q <= sp.first;
        ye_q <= sp.last;
      end
      S_CHK: begin
        if (state_d == S_IDLE) res_q <= '{pixel_byte: 8'hFF, span_error: 1'b1};
      end
      S_PX: begin
        h_q <= 32'(x) * HASH_X;
        if (i_q[3]) res_q <= '{pixel_byte: byte_q, span_error: 1'b0};
      end
      S_XS: begin
        a_q <= pos_sum;
        h_q <= h_q + 32'(y_q) * HASH_Y;
      end
      S_XE: begin
        xs_q  <= sp.first[9:0];
        xe_q  <= sp.last[9:0];
        sx_q  <= sp.first[9:0];
        r_q   <= ys_q;
        w_q   <= 8'd0;
        cnt_q <= 8'd0;
        h_q   <= h_mix;
      end
      S_RD: sxb_q <= sx_q[2:0];
      S_ACC: begin
        w_q   <= w_next;
        cnt_q <= cnt_q + 8'd1;
        if (sx_q + 10'd1 < xe_q) begin
          sx_q <= sx_q + 10'd1;
        end else begin
          sx_q <= xs_q;
          r_q  <= r_q + 11'd1;
        end
        // Sum of 0/255 values is the white count times 255.
        quo_q <= {w_next, 8'd0} - 16'(w_next);
        rem_q <= 8'd0;
      end
      S_DIV: begin
        if (shifted >= {1'b0, cnt_q}) begin
          rem_q <= 8'(shifted - {1'b0, cnt_q});
          quo_q <= {quo_q[14:0], 1'b1};
        end else begin
          rem_q <= shifted[7:0];
          quo_q <= {quo_q[14:0], 1'b0};
        end
      end
      S_CMP: begin
        if (quo_q[7:0] < thr) byte_q[3'd7 - i_q[2:0]] <= 1'b0;
      end
      default: ;
    endcase
  end

  // Single-port byte store: loads write while idle, the sequencer reads.
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.command == CMD_LOAD) begin
      source_store_q[waddr_ext[AW-1:0]] <= cmd_i.load_byte;
    end
    if (state_q == S_RD) begin
      rd_q <= source_store_q[raddr_ext[AW-1:0]];
    end
  end

endmodule

// ===== rtl/bbdd_checker.sv =====
// ----------------------------------------------------------------------------
// Bilevel box downscaler port checker
// Watches the command and result beats on the top-level ports.
// ----------------------------------------------------------------------------
module bbdd_checker
  import bbdd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input cmd_t cmd_i,
  input logic done_o,
  input res_t res_o
);

  // A result beat closes a compute, so the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result beat without a compute");

  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.command == CMD_LOAD) |=> !busy_o && !done_o)
    else $error("load beat did not complete in one cycle");

  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.command == CMD_COMPUTE) |=> busy_o)
    else $error("compute beat not started");

  a_error_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.span_error) |-> res_o.pixel_byte == 8'hFF)
    else $error("span error with non-white byte");

endmodule

bind bilevel_box_downscale_dither bbdd_checker u_bbdd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .cmd_i   (cmd_i),
  .done_o  (done_o),
  .res_o   (res_o)
);
